>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers clocked on aclk, disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// prop must hold at every enabled clock edge
`define ASSERT_PROP(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// cond must never be true at an enabled clock edge
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(label, prop, msg)
`define ASSERT_NEVER(label, cond, msg)

`endif

`endif

>>> rtl/core/adsr_pkg.sv
// ----------------------------------------------------------------------------
// ADSR envelope package
// Types, register indexes, reset values and the rate table.
// ----------------------------------------------------------------------------
package adsr_pkg;

    localparam int LEVEL_W  = 16;
    localparam int RATE_W   = 4;
    localparam int MOD_W    = 11;
    localparam int CODE_W   = 3;
    localparam int VOL_W    = 4;
    localparam int CFG_IX_W = 3;
    localparam int CFG_D_W  = 4;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 24;

    // register indexes
    localparam logic [CFG_IX_W-1:0] REG_ATTACK    = 3'd0;
    localparam logic [CFG_IX_W-1:0] REG_DECAY     = 3'd1;
    localparam logic [CFG_IX_W-1:0] REG_SUSTAIN   = 3'd2;
    localparam logic [CFG_IX_W-1:0] REG_RELEASE   = 3'd3;
    localparam logic [CFG_IX_W-1:0] REG_RETRIGGER = 3'd4;

    // reset values
    localparam logic [RATE_W-1:0] RST_ATTACK  = 4'd0;
    localparam logic [RATE_W-1:0] RST_DECAY   = 4'd6;
    localparam logic [RATE_W-1:0] RST_SUSTAIN = 4'd12;
    localparam logic [RATE_W-1:0] RST_RELEASE = 4'd5;
    localparam logic              RST_RETRIG  = 1'b1;

    localparam logic [LEVEL_W-1:0] LEVEL_FULL = 16'hFFFF;

    // phase codes as seen on the result channel
    localparam logic [CODE_W-1:0] CODE_IDLE    = 3'd0;
    localparam logic [CODE_W-1:0] CODE_ATTACK  = 3'd1;
    localparam logic [CODE_W-1:0] CODE_DECAY   = 3'd2;
    localparam logic [CODE_W-1:0] CODE_SUSTAIN = 3'd3;
    localparam logic [CODE_W-1:0] CODE_RELEASE = 3'd4;

    localparam logic [LEVEL_W-1:0] RATE_STEP [16] = '{
        16'd65535, 16'd16384, 16'd8192, 16'd4096, 16'd2048, 16'd1024, 16'd512, 16'd256,
        16'd128,   16'd64,    16'd32,   16'd16,   16'd8,    16'd4,    16'd2,   16'd1
    };

    typedef enum logic [4:0] {
        PH_IDLE    = 5'b00001,
        PH_ATTACK  = 5'b00010,
        PH_DECAY   = 5'b00100,
        PH_SUSTAIN = 5'b01000,
        PH_RELEASE = 5'b10000
    } adsr_phase_t;

    typedef struct packed {
        logic [RATE_W-1:0] attack_rate;
        logic [RATE_W-1:0] decay_rate;
        logic [RATE_W-1:0] sustain_step;
        logic [RATE_W-1:0] release_rate;
        logic              retrigger_reset;
    } adsr_cfg_t;

    typedef struct packed {
        logic                    gate_held;
        logic                    trigger;
        logic signed [MOD_W-1:0] decay_mod;
    } adsr_item_t;

    typedef struct packed {
        adsr_phase_t        phase;
        logic [LEVEL_W-1:0] level;
        logic               note;
    } adsr_state_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] env_level;
        logic [VOL_W-1:0]   volume;
        logic               note_active;
        logic [CODE_W-1:0]  phase;
    } adsr_result_t;

    function automatic logic [CODE_W-1:0] phase_code(adsr_phase_t ph);
        logic [CODE_W-1:0] code;
        unique case (ph)
            PH_ATTACK:  code = CODE_ATTACK;
            PH_DECAY:   code = CODE_DECAY;
            PH_SUSTAIN: code = CODE_SUSTAIN;
            PH_RELEASE: code = CODE_RELEASE;
            default:    code = CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

>>> rtl/core/adsr_step.sv
// ----------------------------------------------------------------------------
// ADSR tick update
// Next phase, level and note flag for one control tick, plus the result item.
// ----------------------------------------------------------------------------
module adsr_step
    import adsr_pkg::*;
(
    input  adsr_cfg_t    cfg,
    input  adsr_item_t   item,
    input  adsr_state_t  cur,
    output adsr_state_t  nxt,
    output adsr_result_t result
);

    logic signed [5:0]    mod_sh;
    logic signed [6:0]    dec_sum;
    logic [RATE_W-1:0]    dec_ix;
    logic [LEVEL_W-1:0]   sus;
    logic [LEVEL_W-1:0]   atk_step;
    logic [LEVEL_W-1:0]   dec_step;
    logic [LEVEL_W-1:0]   rel_step;
    adsr_phase_t          ph_pre;
    logic [LEVEL_W-1:0]   lvl_pre;
    logic                 note_pre;
    logic [LEVEL_W:0]     sum_atk;
    logic [LEVEL_W:0]     diff_dec;
    logic [VOL_W-1:0]     vol_raw;

    // floor shift by 32 is just the top six bits
    assign mod_sh  = item.decay_mod[MOD_W-1:5];
    assign dec_sum = $signed({3'b000, cfg.decay_rate}) + $signed({mod_sh[5], mod_sh});

    always_comb begin
        if (dec_sum[6]) begin
            dec_ix = '0;
        end else if (dec_sum > 7'sd15) begin
            dec_ix = 4'd15;
        end else begin
            dec_ix = dec_sum[RATE_W-1:0];
        end
    end

    // step * 4369 == step replicated into each nibble
    assign sus      = {4{cfg.sustain_step}};
    assign atk_step = RATE_STEP[cfg.attack_rate];
    assign dec_step = RATE_STEP[dec_ix];
    assign rel_step = RATE_STEP[cfg.release_rate];

    // trigger first, then gate-off
    always_comb begin
        ph_pre   = cur.phase;
        lvl_pre  = cur.level;
        note_pre = cur.note;
        if (item.trigger) begin
            note_pre = 1'b1;
            if (cfg.attack_rate == '0) begin
                ph_pre  = PH_DECAY;
                lvl_pre = LEVEL_FULL;
            end else begin
                ph_pre = PH_ATTACK;
                if (cfg.retrigger_reset) begin
                    lvl_pre = '0;
                end
            end
        end else if (!item.gate_held && cur.note && cur.phase != PH_RELEASE) begin
            ph_pre = PH_RELEASE;
        end
    end

    assign sum_atk  = {1'b0, lvl_pre} + {1'b0, atk_step};
    assign diff_dec = {1'b0, lvl_pre} - {1'b0, dec_step};

    always_comb begin
        nxt.phase = ph_pre;
        nxt.level = lvl_pre;
        nxt.note  = note_pre;
        unique case (ph_pre)
            PH_ATTACK: begin
                if (sum_atk >= {1'b0, LEVEL_FULL}) begin
                    nxt.level = LEVEL_FULL;
                    nxt.phase = PH_DECAY;
                end else begin
                    nxt.level = sum_atk[LEVEL_W-1:0];
                end
            end
            PH_DECAY: begin
                // borrow means the difference went below zero
                if (diff_dec[LEVEL_W] || diff_dec[LEVEL_W-1:0] <= sus) begin
                    nxt.level = sus;
                    nxt.phase = PH_SUSTAIN;
                end else begin
                    nxt.level = diff_dec[LEVEL_W-1:0];
                end
            end
            PH_SUSTAIN: begin
                nxt.level = sus;
            end
            PH_RELEASE: begin
                if (lvl_pre <= rel_step) begin
                    nxt.level = '0;
                    nxt.phase = PH_IDLE;
                    nxt.note  = 1'b0;
                end else begin
                    nxt.level = lvl_pre - rel_step;
                end
            end
            default: begin
                nxt.level = '0;
                nxt.phase = PH_IDLE;
            end
        endcase
    end

    assign vol_raw = nxt.level[LEVEL_W-1:LEVEL_W-VOL_W];

    always_comb begin
        result.env_level   = nxt.level;
        result.note_active = nxt.note;
        result.phase       = phase_code(nxt.phase);
        if (vol_raw == '0 && nxt.phase != PH_IDLE) begin
            result.volume = 4'd1;
        end else begin
            result.volume = vol_raw;
        end
    end

endmodule

>>> rtl/core/adsr_envelope_generator.sv
// ----------------------------------------------------------------------------
// ADSR envelope generator
// Control-tick driven 16-bit envelope with attack, decay, sustain and release.
// ----------------------------------------------------------------------------
// Usage:
//   Each slave transaction is one control tick: gate level, trigger flag and
//   signed decay modulation. Each tick yields exactly one master transaction
//   with the new level, 4-bit volume, note-on flag and phase code.
//   Envelope timing is set through the write port (attack, decay, sustain,
//   release indexes and retrigger mode); write it only with no tick in flight.
// Pipeline and throughput:
//   A tick is captured in the input register and passes the single-pass
//   step logic into the output register once the output slot is free or
//   draining; m_tvalid then rises. One tick per cycle is sustained while
//   m_tready stays high, set by the phase/level feedback through the step
//   logic.
// Reset:
//   Synchronous, active low. Phase returns to idle, level and note flag clear,
//   configuration takes its defaults and both channels empty.
// Stalls:
//   While m_tready is low the result holds; one further tick waits in the
//   input register, after which s_tready drops.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module adsr_envelope_generator
    import adsr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IX_W-1:0]   cfg_addr,
    input  logic [CFG_D_W-1:0]    cfg_wdata,
    // tick input
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // [0] gate_held, [1] trigger, [12:2] decay_mod
    // result output
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata    // [15:0] env_level, [19:16] volume,
                                             // [20] note_active, [23:21] phase
);

    adsr_cfg_t    cfg_reg;
    adsr_item_t   item_reg;
    logic         in_valid_reg;
    adsr_state_t  state_reg;
    adsr_state_t  state_next;
    adsr_result_t result_next;
    adsr_result_t result_reg;
    logic         out_valid_reg;
    logic         fire;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.attack_rate     <= RST_ATTACK;
            cfg_reg.decay_rate      <= RST_DECAY;
            cfg_reg.sustain_step    <= RST_SUSTAIN;
            cfg_reg.release_rate    <= RST_RELEASE;
            cfg_reg.retrigger_reset <= RST_RETRIG;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_ATTACK:    cfg_reg.attack_rate     <= cfg_wdata;
                REG_DECAY:     cfg_reg.decay_rate      <= cfg_wdata;
                REG_SUSTAIN:   cfg_reg.sustain_step    <= cfg_wdata;
                REG_RELEASE:   cfg_reg.release_rate    <= cfg_wdata;
                REG_RETRIGGER: cfg_reg.retrigger_reset <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // step fires when a tick is held and the output slot is free or draining
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg.gate_held <= s_tdata[0];
            item_reg.trigger   <= s_tdata[1];
            item_reg.decay_mod <= s_tdata[12:2];
        end
    end

    adsr_step u_step (
        .cfg    (cfg_reg),
        .item   (item_reg),
        .cur    (state_reg),
        .nxt    (state_next),
        .result (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase <= PH_IDLE;
            state_reg.level <= '0;
            state_reg.note  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (fire) begin
                state_reg <= state_next;
            end
            out_valid_reg <= fire || (out_valid_reg && !m_tready);
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {result_reg.phase, result_reg.note_active,
                       result_reg.volume, result_reg.env_level};

    // idle exactly when no note is sounding
    `ASSERT_PROP(a_idle_note, (state_reg.phase == PH_IDLE) == !state_reg.note, "idle/note mismatch")
    `ASSERT_PROP(a_idle_zero, (state_reg.phase == PH_IDLE) |-> (state_reg.level == '0), "idle level not zero")
    `ASSERT_NEVER(a_vol_floor, m_tvalid && result_reg.phase != CODE_IDLE && result_reg.volume == '0, "zero volume on sounding note")

endmodule

>>> sim/tb_adsr_envelope_generator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ADSR envelope generator testbench
// Streams control ticks into the envelope generator and checks every result
// against a cycle-free model of the envelope kept in the bench, or against
// the expected values of a short table of directed ticks and register writes
// that comes first. Note-shaped random traffic follows under a series of
// register settings, extremes first. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_adsr_envelope_generator;
    import adsr_pkg::*;

    localparam int STALL_LIMIT       = 400;
    localparam int SEGMENTS          = 10;
    localparam int ITEMS_PER_SEGMENT = 35;
    localparam int SUSTAIN_SCALE     = 4369;
    localparam int FULL_SCALE        = 65535;

    // no register lives here; writes to it must be dropped
    localparam logic [CFG_IX_W-1:0] REG_SPARE = 3'd5;

    typedef struct packed {
        logic [S_DATA_W-14:0]    pad;
        logic signed [MOD_W-1:0] decay_mod;
        logic                    trigger;
        logic                    gate_held;
    } tick_t;

    typedef struct packed {
        logic [CODE_W-1:0]  phase;
        logic               note_active;
        logic [VOL_W-1:0]   volume;
        logic [LEVEL_W-1:0] env_level;
    } envelope_out_t;

    typedef enum bit {ROW_TICK, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t               kind;
        logic                    gate;
        logic                    trig;
        logic signed [MOD_W-1:0] mod;
        logic [CFG_IX_W-1:0]     addr;
        logic [CFG_D_W-1:0]      data;
        bit                      typed;
        envelope_out_t           want;
    } row_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [CFG_IX_W-1:0] cfg_addr  = '0;
    logic [CFG_D_W-1:0]  cfg_wdata = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    // bench copy of the registers and the envelope
    logic [RATE_W-1:0]  att_ix      = RST_ATTACK;
    logic [RATE_W-1:0]  dec_base    = RST_DECAY;
    logic [RATE_W-1:0]  sus_step    = RST_SUSTAIN;
    logic [RATE_W-1:0]  rel_ix      = RST_RELEASE;
    logic               retrig_zero = RST_RETRIG;
    logic [CODE_W-1:0]  env_phase   = CODE_IDLE;
    int                 env_level   = 0;
    logic               note_on     = 1'b0;

    envelope_out_t envelope_due[$];
    int            mismatches  = 0;
    int            idle_cycles = 0;
    bit            no_idle     = 1'b0;

    adsr_envelope_generator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic int step_size(logic [RATE_W-1:0] ix);
        return (ix == 0) ? FULL_SCALE : (1 << (15 - ix));
    endfunction

    function automatic void apply_setting(logic [CFG_IX_W-1:0] addr, logic [CFG_D_W-1:0] data);
        case (addr)
            REG_ATTACK:    att_ix = data[RATE_W-1:0];
            REG_DECAY:     dec_base = data[RATE_W-1:0];
            REG_SUSTAIN:   sus_step = data[RATE_W-1:0];
            REG_RELEASE:   rel_ix = data[RATE_W-1:0];
            REG_RETRIGGER: retrig_zero = data[0];
            default: ;
        endcase
    endfunction

    function automatic envelope_out_t advance_envelope(tick_t tk);
        int            dec_ix;
        int            sus_level;
        envelope_out_t r;
        // modulation floors on the shift, then the index is clamped
        dec_ix = int'(dec_base) + (int'(tk.decay_mod) >>> 5);
        if (dec_ix < 0) dec_ix = 0;
        else if (dec_ix > 15) dec_ix = 15;
        sus_level = int'(sus_step) * SUSTAIN_SCALE;

        if (tk.trigger) begin
            if (att_ix == 0) begin
                env_phase = CODE_DECAY;
                env_level = FULL_SCALE;
            end else begin
                env_phase = CODE_ATTACK;
                if (retrig_zero) env_level = 0;
            end
            note_on = 1'b1;
        end else if (!tk.gate_held && note_on && env_phase != CODE_RELEASE) begin
            env_phase = CODE_RELEASE;
        end

        case (env_phase)
            CODE_ATTACK: begin
                env_level += step_size(att_ix);
                if (env_level >= FULL_SCALE) begin
                    env_level = FULL_SCALE;
                    env_phase = CODE_DECAY;
                end
            end
            CODE_DECAY: begin
                env_level -= step_size(RATE_W'(dec_ix));
                if (env_level <= sus_level) begin
                    env_level = sus_level;
                    env_phase = CODE_SUSTAIN;
                end
            end
            CODE_SUSTAIN: env_level = sus_level;
            CODE_RELEASE: begin
                env_level -= step_size(rel_ix);
                if (env_level <= 0) begin
                    env_level = 0;
                    env_phase = CODE_IDLE;
                    note_on   = 1'b0;
                end
            end
            default: begin
                env_phase = CODE_IDLE;
                env_level = 0;
            end
        endcase

        r.env_level   = env_level[LEVEL_W-1:0];
        r.volume      = env_level[15:12];
        if (r.volume == 0 && env_phase != CODE_IDLE) r.volume = 1;
        r.note_active = note_on;
        r.phase       = env_phase;
        return r;
    endfunction

    function automatic row_t tick_row(logic g, logic t, logic signed [MOD_W-1:0] m);
        row_t r;
        r.kind  = ROW_TICK;
        r.gate  = g;
        r.trig  = t;
        r.mod   = m;
        r.addr  = '0;
        r.data  = '0;
        r.typed = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    function automatic row_t known_row(logic g, logic t, logic signed [MOD_W-1:0] m,
                                       int lvl, int vol, logic note, logic [CODE_W-1:0] ph);
        row_t r;
        r = tick_row(g, t, m);
        r.typed = 1'b1;
        r.want  = '{phase: ph, note_active: note, volume: VOL_W'(vol),
                    env_level: LEVEL_W'(lvl)};
        return r;
    endfunction

    function automatic row_t write_row(logic [CFG_IX_W-1:0] addr, logic [CFG_D_W-1:0] data);
        row_t r;
        r = tick_row(1'b0, 1'b0, '0);
        r.kind = ROW_WRITE;
        r.addr = addr;
        r.data = data;
        return r;
    endfunction

    task automatic send_tick(logic g, logic t, logic signed [MOD_W-1:0] m,
                             bit typed, envelope_out_t want);
        tick_t         tk;
        envelope_out_t pred;
        int            gap;
        tk  = '{pad: '0, decay_mod: m, trigger: t, gate_held: g};
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= tk;
        do @(posedge aclk); while (s_tready !== 1'b1);
        pred = advance_envelope(tk);
        envelope_due.push_back(typed ? want : pred);
    endtask

    // hold off the sender until every outstanding result is back
    task automatic drain;
        s_tvalid <= 1'b0;
        while (envelope_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_setting(logic [CFG_IX_W-1:0] addr, logic [CFG_D_W-1:0] data);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        apply_setting(addr, data);
    endtask

    function automatic logic [RATE_W-1:0] pick_rate;
        // mostly quick rates so that notes run through all phases
        return ($urandom_range(0, 3) == 0) ? RATE_W'($urandom_range(0, 15))
                                           : RATE_W'($urandom_range(0, 5));
    endfunction

    function automatic logic signed [MOD_W-1:0] pick_mod;
        case ($urandom_range(0, 7))
            0: return -11'sd1024;
            1: return 11'sd1023;
            2: return MOD_W'($urandom_range(0, 63)) - 11'sd32;
            default: return MOD_W'($urandom_range(0, 2047));
        endcase
    endfunction

    // stimulus
    initial begin
        row_t script[$];
        int   n;
        int   hold;
        int   tail;
        script = '{
            known_row(1'b0, 1'b0, 11'sd0, 0, 0, 1'b0, CODE_IDLE),
            known_row(1'b1, 1'b1, 11'sd0, 65023, 15, 1'b1, CODE_DECAY),
            known_row(1'b1, 1'b0, -11'sd1024, 52428, 12, 1'b1, CODE_SUSTAIN),
            known_row(1'b1, 1'b0, 11'sd1023, 52428, 12, 1'b1, CODE_SUSTAIN),
            known_row(1'b0, 1'b0, 11'sd0, 51404, 12, 1'b1, CODE_RELEASE),
            // trigger with gate low: trigger wins, release follows
            known_row(1'b0, 1'b1, 11'sd0, 65023, 15, 1'b1, CODE_DECAY),
            tick_row(1'b0, 1'b0, -11'sd33),
            write_row(REG_RELEASE, 4'd0),
            known_row(1'b0, 1'b0, 11'sd0, 0, 0, 1'b0, CODE_IDLE),
            write_row(REG_ATTACK, 4'd15),
            write_row(REG_DECAY, 4'd15),
            // level 1 in attack: volume floored at one
            known_row(1'b1, 1'b1, 11'sd31, 1, 1, 1'b1, CODE_ATTACK),
            write_row(REG_ATTACK, 4'd1),
            tick_row(1'b1, 1'b0, -11'sd32),
            tick_row(1'b1, 1'b0, 11'sd32),
            tick_row(1'b1, 1'b0, -11'sd1),
            tick_row(1'b1, 1'b0, 11'sd0),
            tick_row(1'b1, 1'b0, 11'sd1023),
            // sustain raised above the decaying level
            write_row(REG_SUSTAIN, 4'd15),
            tick_row(1'b1, 1'b0, 11'sd0),
            // upper bits dropped: retrigger mode goes to zero
            write_row(REG_RETRIGGER, 4'b1110),
            tick_row(1'b1, 1'b1, 11'sd0),
            write_row(REG_SPARE, 4'd15),
            tick_row(1'b0, 1'b0, 11'sd0),
            tick_row(1'b0, 1'b0, 11'sd0)
        };

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (script[i]) begin
            if (script[i].kind == ROW_WRITE) begin
                write_setting(script[i].addr, script[i].data);
            end else begin
                send_tick(script[i].gate, script[i].trig, script[i].mod,
                          script[i].typed, script[i].want);
            end
        end

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            if (seg == 0) begin
                write_setting(REG_ATTACK, 4'd0);
                write_setting(REG_DECAY, 4'd0);
                write_setting(REG_SUSTAIN, 4'd0);
                write_setting(REG_RELEASE, 4'd0);
                write_setting(REG_RETRIGGER, 4'd0);
            end else if (seg == 1) begin
                write_setting(REG_ATTACK, 4'd15);
                write_setting(REG_DECAY, 4'd15);
                write_setting(REG_SUSTAIN, 4'd15);
                write_setting(REG_RELEASE, 4'd15);
                write_setting(REG_RETRIGGER, 4'd1);
            end else begin
                write_setting(REG_ATTACK, pick_rate());
                write_setting(REG_DECAY, pick_rate());
                write_setting(REG_SUSTAIN, CFG_D_W'($urandom_range(0, 15)));
                write_setting(REG_RELEASE, pick_rate());
                write_setting(REG_RETRIGGER, CFG_D_W'($urandom_range(0, 1)));
            end
            no_idle = ($urandom_range(0, 3) == 0);
            n = 0;
            while (n < ITEMS_PER_SEGMENT) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              pick_mod(), 1'b0, '0);
                    n++;
                end else begin
                    // one note: trigger, held gate, then released gate
                    hold = $urandom_range(0, 24);
                    tail = $urandom_range(0, 24);
                    send_tick($urandom_range(0, 7) != 0, 1'b1, pick_mod(), 1'b0, '0);
                    repeat (hold) send_tick(1'b1, 1'b0, pick_mod(), 1'b0, '0);
                    repeat (tail) send_tick(1'b0, 1'b0, pick_mod(), 1'b0, '0);
                    n += 1 + hold + tail;
                end
            end
            no_idle = 1'b0;
        end

        s_tvalid <= 1'b0;
        while (envelope_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("tb_adsr_envelope_generator passed");
        end else begin
            $display("tb_adsr_envelope_generator failed");
        end
        $finish;
    end

    // result side: random stalls, each transaction checked in order
    initial begin
        int            stall;
        envelope_out_t got;
        envelope_out_t want;
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1 || aresetn !== 1'b1);
            got = m_tdata;
            if (envelope_due.size() == 0) begin
                $display("%0t: result with nothing expected, got %h", $time, got);
                mismatches++;
            end else begin
                want = envelope_due.pop_front();
                if (got.env_level !== want.env_level) begin
                    $display("%0t: env_level expected %0d got %0d",
                             $time, want.env_level, got.env_level);
                    mismatches++;
                end
                if (got.volume !== want.volume) begin
                    $display("%0t: volume expected %0d got %0d",
                             $time, want.volume, got.volume);
                    mismatches++;
                end
                if (got.note_active !== want.note_active) begin
                    $display("%0t: note_active expected %0b got %0b",
                             $time, want.note_active, got.note_active);
                    mismatches++;
                end
                if (got.phase !== want.phase) begin
                    $display("%0t: phase expected %0d got %0d",
                             $time, want.phase, got.phase);
                    mismatches++;
                end
            end
        end
    end

    // watchdog: too long without any transaction on either channel
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
            $display("tb_adsr_envelope_generator failed");
            $finish;
        end
    end

endmodule
